[rtl/swm_pkg.sv]
package swm_pkg;

  // Defaults for the top-level parameters.
  localparam int WindowMaxDef   = 64;
  localparam int SampleWidthDef = 32;

  // Width of the window_size register.
  localparam int CfgWidth = 7;

  // Control that the top level broadcasts to every cell of the chain.
  typedef struct packed {
    logic take;     // a word is accepted this cycle
    logic restart;  // the accepted word opens a new stream
    logic flush;    // window_size is written, so the window empties
  } swm_ctrl_t;

endpackage

[rtl/swm_cell.sv]
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_ctrl_t                      ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_val,
  input  logic                           prev_vld,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                           vld,
  output logic signed [SAMPLE_WIDTH-1:0] val_next,
  output logic                           vld_next
);

  // Cell i holds the maximum of the last i+1 samples. A new sample turns the
  // neighbor's maximum over i samples into this cell's maximum over i+1.
  logic prev_live;

  assign prev_live = prev_vld & ~ctrl.restart;

  always_comb begin
    val_next = val;
    vld_next = vld;
    if (ctrl.flush) begin
      vld_next = 1'b0;
    end else if (ctrl.take) begin
      vld_next = prev_live;
      val_next = sample;
      if (prev_live && (prev_val > sample)) begin
        val_next = prev_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

endmodule

[rtl/swm_head.sv]
module swm_head
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_ctrl_t                      ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                           vld,
  output logic signed [SAMPLE_WIDTH-1:0] val_next,
  output logic                           vld_next
);

  // The first cell holds the newest sample alone: valid after any word.
  always_comb begin
    val_next = val;
    vld_next = vld;
    if (ctrl.flush) begin
      vld_next = 1'b0;
    end else if (ctrl.take) begin
      vld_next = 1'b1;
      val_next = sample;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

endmodule

[rtl/sliding_window_maximum.sv]
// Sliding-window maximum over a stream of signed samples.
// A result word appears in the cycle after its sample word is accepted.
// Throughput: one sample word per cycle while the result channel does not stall;
// the row of cells updates all at once. Reset (synchronous, active high): every
// cell empty, window size one, no result pending.
module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WindowMaxDef,
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           window_size_we,
  input  logic [CfgWidth-1:0]            window_size,
  // Sample channel.
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           stream_start,
  // Result channel.
  output logic                           max_valid,
  input  logic                           max_stall,
  output logic signed [SAMPLE_WIDTH-1:0] window_max
);

  localparam int IdxW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CmpW = ((CfgWidth > IdxW) ? CfgWidth : IdxW) + 1;

  // The chain is a row of cells where cell i keeps the maximum of the last
  // i+1 samples of the current stream, together with a valid flag that is set
  // once at least i+1 samples have arrived. On every accepted word each cell
  // takes its left neighbor's maximum, compares it with the new sample and
  // keeps the larger. The answer for a window of w samples is then simply
  // cell w-1, and its valid flag tells whether w samples have been seen.

  // Effective window size minus one, so that it indexes the cell row directly.
  logic [IdxW-1:0] win_last;
  logic [CmpW-1:0] ws_wide;
  logic [IdxW-1:0] win_last_next;

  swm_ctrl_t ctrl;
  logic      take;

  logic signed [SAMPLE_WIDTH-1:0] cell_val      [WINDOW_MAX];
  logic                           cell_vld      [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_val_next [WINDOW_MAX];
  logic                           cell_vld_next [WINDOW_MAX];

  // A new word is taken whenever the result register is empty or is being
  // emptied in the same cycle.
  assign sample_stall = max_valid & max_stall;
  assign take         = sample_valid & ~sample_stall;

  assign ctrl.take    = take;
  assign ctrl.restart = stream_start;
  assign ctrl.flush   = window_size_we;

  // A window of zero acts as one, and anything beyond the row length acts
  // as the full row.
  assign ws_wide = CmpW'(window_size);

  always_comb begin
    if (ws_wide == '0) begin
      win_last_next = '0;
    end else if (ws_wide > CmpW'(WINDOW_MAX)) begin
      win_last_next = IdxW'(WINDOW_MAX - 1);
    end else begin
      win_last_next = IdxW'(ws_wide - CmpW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_last <= '0;
    end else if (window_size_we) begin
      win_last <= win_last_next;
    end
  end

  // The first cell only ever holds the newest sample.
  swm_head #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_head (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (sample),
    .val     (cell_val[0]),
    .vld     (cell_vld[0]),
    .val_next(cell_val_next[0]),
    .vld_next(cell_vld_next[0])
  );

  // Each further cell extends its neighbor's window by one sample.
  for (genvar i = 1; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sample  (sample),
      .prev_val(cell_val[i-1]),
      .prev_vld(cell_vld[i-1]),
      .val     (cell_val[i]),
      .vld     (cell_vld[i]),
      .val_next(cell_val_next[i]),
      .vld_next(cell_vld_next[i])
    );
  end

  // The result register picks the cell that covers exactly the window, as it
  // stands after this word. No result leaves until the stream has filled the
  // window, which is what the cell's valid flag reports.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_valid <= 1'b0;
    end else if (take) begin
      max_valid <= cell_vld_next[win_last];
    end else if (!max_stall) begin
      max_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      window_max <= cell_val_next[win_last];
    end
  end

endmodule
